// ----- design/lpft_pkg.sv -----
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants for the LRU page frame tracker.
// ----------------------------------------------------------------------------
package lpft_pkg;

    // Default geometry
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // Frame limit register
    localparam int               CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Request kinds
    typedef enum logic
    {
        REQ_REF  = 1'b0,
        REQ_FREE = 1'b1
    } req_kind_t;

    // Per-cell update command
    typedef enum logic [1:0]
    {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } cell_op_t;

endpackage : lpft_pkg

// ----- design/lpft_if.sv -----
// ----------------------------------------------------------------------------
// lpft_if
// Valid/ready channels of the tracker: request, response and limit write.
// ----------------------------------------------------------------------------
interface lpft_req_if
    import lpft_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output req_type, output page, input ready);
    modport sink   (input valid, input req_type, input page, output ready);
endinterface : lpft_req_if

interface lpft_rsp_if
    import lpft_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int CNT_W     = 5
)
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 error;
    logic [CNT_W-1:0]     occupied;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output error, output occupied, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input error, input occupied, output ready);
endinterface : lpft_rsp_if

interface lpft_cfg_if
    import lpft_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface : lpft_cfg_if

// ----- design/lpft_cell.sv -----
// ----------------------------------------------------------------------------
// lpft_cell
// One recency slot: holds a page number and its valid bit, and takes the
// new page or a neighbor's entry on command.
// ----------------------------------------------------------------------------
module lpft_cell
    import lpft_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_op_t             op,
    input  logic [PAGE_BITS-1:0] load_page,
    input  logic [PAGE_BITS-1:0] prev_page,
    input  logic                 prev_valid,
    input  logic [PAGE_BITS-1:0] next_page,
    input  logic                 next_valid,
    input  logic [PAGE_BITS-1:0] lookup_page,
    output logic [PAGE_BITS-1:0] page,
    output logic                 valid,
    output logic                 match
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_next;

    // Next entry by command
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        unique case (op)
            CELL_HOLD:
            begin
                page_next  = page_reg;
                valid_next = valid_reg;
            end
            CELL_LOAD:
            begin
                page_next  = load_page;
                valid_next = 1'b1;
            end
            CELL_FROM_PREV:
            begin
                page_next  = prev_page;
                valid_next = prev_valid;
            end
            CELL_FROM_NEXT:
            begin
                page_next  = next_page;
                valid_next = next_valid;
            end
            default:
            begin
                page_next  = page_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid bit, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Page number, meaningful only while valid
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;
    // tag compare for the lookup
    assign match = valid_reg && (page_reg == lookup_page);

endmodule : lpft_cell

// ----- design/lpft_scan.sv -----
// ----------------------------------------------------------------------------
// lpft_scan
// Parallel prefix OR over the cell match lines (log-depth, independent
// elements per level). Bit i is set when a match sits at position i or lower.
// ----------------------------------------------------------------------------
module lpft_scan
    import lpft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic [FRAMES-1:0] match,
    output logic [FRAMES-1:0] prefix
);

    localparam int LEVELS = $clog2(FRAMES);

    logic [FRAMES-1:0] lvl [LEVELS+1];

    assign lvl[0] = match;

    // Each level folds in the entry 2^k places lower
    for (genvar k = 0; k < LEVELS; k++)
    begin : g_level
        for (genvar i = 0; i < FRAMES; i++)
        begin : g_bit
            if (i >= (1 << k))
            begin : g_fold
                assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
            end
            else
            begin : g_pass
                assign lvl[k+1][i] = lvl[k][i];
            end
        end
    end

    assign prefix = lvl[LEVELS];

endmodule : lpft_scan

// ----- design/lru_page_frame_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// lru_page_frame_tracker_unit
// LRU replacement stack for page frames, built as a chain of recency cells.
// ----------------------------------------------------------------------------
// Each request is handled as follows: it is accepted, every cell compares
// its page against the request in parallel, a log-depth prefix OR over the
// match lines tells each cell which way to move, and all cells update at the
// same edge while the result is captured in the output register. The result
// item is offered the cycle after acceptance, and a new request is taken in
// that same cycle as long as the result register is empty or being drained,
// so the sustained rate is one item per cycle. Position 0 is the most
// recently used page; valid entries stay packed toward position 0. No
// clearing pass is needed after reset. The frame limit may be rewritten only
// while the block is idle; a limit of 0 acts as 1 and one above FRAMES acts
// as FRAMES.
// ----------------------------------------------------------------------------
module lru_page_frame_tracker_unit
    import lpft_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lpft_req_if.sink   req,
    lpft_rsp_if.source rsp,
    lpft_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Chain signals
    logic [FRAMES-1:0]    cell_valid;
    logic [FRAMES-1:0]    cell_match;
    logic [FRAMES-1:0]    match_prefix;
    logic [PAGE_BITS-1:0] cell_page [FRAMES];
    cell_op_t             cell_op   [FRAMES];

    // Control state
    logic [CFG_W-1:0] frames_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    // Result register
    logic                 rsp_valid_reg;
    logic                 hit_reg;
    logic                 ev_valid_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic                 error_reg;

    // Request decode
    logic                 accept;
    logic                 is_free;
    logic                 any_hit;
    logic                 full;
    logic                 do_evict;
    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     limit;
    logic [CMP_W-1:0]     occ_ext;
    logic [FRAMES-1:0]    valid_up;
    logic [FRAMES-1:0]    valid_dn;
    logic [FRAMES-1:0]    prefix_up;
    logic [FRAMES-1:0]    is_last;
    logic [FRAMES-1:0]    ev_bits [PAGE_BITS];
    logic [PAGE_BITS-1:0] ev_page;

    // Handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Recency cells
    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lpft_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (cell_op[i]),
            .load_page   (req.page),
            .prev_page   ((i == 0) ? '0 : cell_page[(i == 0) ? 0 : i - 1]),
            .prev_valid  (valid_up[i]),
            .next_page   ((i == FRAMES - 1) ? '0 : cell_page[(i == FRAMES - 1) ? i : i + 1]),
            .next_valid  (valid_dn[i]),
            .lookup_page (req.page),
            .page        (cell_page[i]),
            .valid       (cell_valid[i]),
            .match       (cell_match[i])
        );
    end

    lpft_scan #(
        .FRAMES (FRAMES)
    ) u_scan (
        .match  (cell_match),
        .prefix (match_prefix)
    );

    // Neighbor views of valid and prefix
    assign valid_up  = {cell_valid[FRAMES-2:0], 1'b0};
    assign valid_dn  = {1'b0, cell_valid[FRAMES-1:1]};
    assign prefix_up = {match_prefix[FRAMES-2:0], 1'b0};
    assign is_last   = cell_valid & ~valid_dn;

    // Effective frame limit and full check
    always_comb
    begin
        cfg_ext = CMP_W'(frames_reg);
        occ_ext = CMP_W'(occ_reg);
        priority if (cfg_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(FRAMES))
        begin
            limit = CMP_W'(FRAMES);
        end
        else
        begin
            limit = cfg_ext;
        end
    end

    assign is_free  = (req.req_type == REQ_FREE);
    assign any_hit  = match_prefix[FRAMES-1];
    assign full     = (occ_ext >= limit);
    assign do_evict = !is_free && !any_hit && full;

    // Page of the rearmost valid cell
    for (genvar b = 0; b < PAGE_BITS; b++)
    begin : g_ev_bit
        for (genvar i = 0; i < FRAMES; i++)
        begin : g_ev_cell
            assign ev_bits[b][i] = is_last[i] & cell_page[i][b];
        end
        assign ev_page[b] = |ev_bits[b];
    end

    // Cell commands
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (accept)
            begin
                if (!is_free)
                begin
                    if (i == 0)
                    begin
                        cell_op[i] = CELL_LOAD;
                    end
                    else if (any_hit)
                    begin
                        // entries above the hit slide back one place
                        cell_op[i] = prefix_up[i] ? CELL_HOLD : CELL_FROM_PREV;
                    end
                    else if (full)
                    begin
                        // rear entry drops out
                        cell_op[i] = cell_valid[i] ? CELL_FROM_PREV : CELL_HOLD;
                    end
                    else
                    begin
                        cell_op[i] = valid_up[i] ? CELL_FROM_PREV : CELL_HOLD;
                    end
                end
                else if (any_hit && match_prefix[i])
                begin
                    // close the gap left by the freed page
                    cell_op[i] = CELL_FROM_NEXT;
                end
            end
        end
    end

    // Occupancy update
    always_comb
    begin
        occ_next = occ_reg;
        if (accept)
        begin
            if (!is_free && !any_hit && !full)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
            else if (is_free && any_hit)
            begin
                occ_next = occ_reg - CNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= CFG_RESET;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                frames_reg <= cfg.frames_in_use;
            end
            occ_reg <= occ_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= any_hit;
            ev_valid_reg <= do_evict;
            ev_page_reg  <= do_evict ? ev_page : '0;
            error_reg    <= is_free && !any_hit;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.evicted_valid = ev_valid_reg;
    assign rsp.evicted_page  = ev_page_reg;
    assign rsp.error         = error_reg;
    assign rsp.occupied      = occ_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // count tracks the number of valid cells
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(occ_reg))
        else $error("occupancy does not match valid cells");

    // valid cells stay packed toward the front
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & ~{cell_valid[FRAMES-2:0], 1'b1}) == '0)
        else $error("recency chain has a hole");

    // a page is resident at most once
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_match))
        else $error("page found in more than one cell");

    // a reference leaves its page at the front
    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_free |=> cell_valid[0] && (cell_page[0] == $past(req.page)))
        else $error("referenced page not at front");

    // an eviction keeps occupancy unchanged
    a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
        accept && do_evict |=> $stable(occ_reg))
        else $error("eviction changed occupancy");

endmodule : lru_page_frame_tracker_unit
